/* src/euclidean_distance_integer_unit_macros.svh */
// Assertion macros shared by the distance unit checker.
`ifndef EUCLIDEAN_DISTANCE_INTEGER_UNIT_MACROS_SVH
`define EUCLIDEAN_DISTANCE_INTEGER_UNIT_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define EDI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked property that must also hold during reset.
`define EDI_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* src/edi_pkg.sv */
// Shared constants and stage payload type for the integer distance unit.
package edi_pkg;

  // Input beat: four 32-bit coordinates
  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned IN_W     = 4 * FIELD_W;

  // Difference datapath: one guard bit plus sign over a 32-bit coordinate
  localparam int unsigned DIFF_W   = FIELD_W + 2;

  // Integer differences are clamped to 17 bits, squares summed into 35 bits
  localparam int unsigned IDIFF_W  = 17;
  localparam int unsigned SQ_W     = 2 * IDIFF_W;
  localparam int unsigned SUM_W    = SQ_W + 1;

  // Root of a 35-bit value has 18 bits
  localparam int unsigned ROOT_W   = (SUM_W + 1) / 2;
  localparam int unsigned DELTA_W  = SUM_W + 2;

  // Output beat: 17-bit distance padded to three bytes
  localparam int unsigned DIST_W   = 17;
  localparam int unsigned OUT_W    = 24;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Payload passed between square root stages
  typedef struct packed {
    logic [SUM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic              sat;
  } root_t;

endpackage

/* src/edi_front.sv */
// Front end: coordinate differences, integer magnitudes, squares and their sum.
module edi_front
  import edi_pkg::*;
#(
  parameter int unsigned COORD_BITS = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [IN_W-1:0] data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output root_t           data_o
);

  localparam int unsigned NSTG   = 4;
  localparam int unsigned LOW_B  = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam bit          HAS_SGN = (COORD_BITS <= FIELD_W);
  localparam logic [DIFF_W-1:0] LOW_MASK = (DIFF_W'(1) << LOW_B) - DIFF_W'(1);

  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] adv;

  // Stage registers
  logic signed [DIFF_W-1:0] dx_q, dy_q;
  logic [IDIFF_W-1:0]       ix_q, iy_q;
  logic                     sat1_q, sat2_q, sat3_q;
  logic [SQ_W-1:0]          sqx_q, sqy_q;
  logic [SUM_W-1:0]         sum_q;

  // Sign-extend the low COORD_BITS of a field, or zero-extend a full field
  function automatic logic [DIFF_W-1:0] coord_ext(input logic [FIELD_W-1:0] raw);
    logic [DIFF_W-1:0] v;
    logic              s;
    v = {{(DIFF_W - FIELD_W){1'b0}}, raw} & LOW_MASK;
    s = HAS_SGN && v[LOW_B-1];
    return s ? (v | ~LOW_MASK) : v;
  endfunction

  // Advance a stage when it is empty or its successor moves
  always_comb begin
    adv[NSTG-1] = !vld_q[NSTG-1] || ready_i;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !vld_q[i] || adv[i+1];
    end
  end

  assign ready_o = adv[0];
  assign valid_o = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= valid_i;
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // Stage 0: full-width differences
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      dx_q <= coord_ext(data_i[0*FIELD_W +: FIELD_W]) - coord_ext(data_i[2*FIELD_W +: FIELD_W]);
      dy_q <= coord_ext(data_i[1*FIELD_W +: FIELD_W]) - coord_ext(data_i[3*FIELD_W +: FIELD_W]);
    end
  end

  // Stage 1: magnitude, drop fraction bits, flag oversize parts
  logic [DIFF_W-1:0] magx, magy, shx, shy;
  always_comb begin
    magx = dx_q[DIFF_W-1] ? DIFF_W'(-dx_q) : DIFF_W'(dx_q);
    magy = dy_q[DIFF_W-1] ? DIFF_W'(-dy_q) : DIFF_W'(dy_q);
    shx  = magx >> FRAC_BITS;
    shy  = magy >> FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      ix_q   <= shx[IDIFF_W-1:0];
      iy_q   <= shy[IDIFF_W-1:0];
      sat1_q <= (|shx[DIFF_W-1:IDIFF_W]) || (|shy[DIFF_W-1:IDIFF_W]);
    end
  end

  // Stage 2: squares
  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      sqx_q  <= ix_q * ix_q;
      sqy_q  <= iy_q * iy_q;
      sat2_q <= sat1_q;
    end
  end

  // Stage 3: sum of squares
  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      sum_q  <= SUM_W'(sqx_q) + SUM_W'(sqy_q);
      sat3_q <= sat2_q;
    end
  end

  assign data_o.rem  = sum_q;
  assign data_o.root = '0;
  assign data_o.sat  = sat3_q;

endmodule

/* src/edi_root_stage.sv */
// One stage of the digit-by-digit square root: settles one root bit.
module edi_root_stage
  import edi_pkg::*;
#(
  parameter int unsigned BIT = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  root_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output root_t data_o
);

  logic              valid_q;
  root_t             data_q;
  logic              adv;
  logic [DELTA_W-1:0] delta;
  logic [DELTA_W-1:0] rem_w;
  logic              take;
  root_t             data_d;

  assign adv     = !valid_q || ready_i;
  assign ready_o = adv;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // Try setting this bit: remainder must cover 2*root*2^BIT + 4^BIT
  always_comb begin
    delta  = (DELTA_W'(data_i.root) << (BIT + 1)) + (DELTA_W'(1) << (2 * BIT));
    rem_w  = DELTA_W'(data_i.rem);
    take   = rem_w >= delta;
    data_d = data_i;
    if (take) begin
      data_d.rem  = data_i.rem - delta[SUM_W-1:0];
      data_d.root = data_i.root | (ROOT_W'(1) << BIT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) data_q <= data_d;
  end

endmodule

/* src/euclidean_distance_integer_unit.sv */
// Top level of the integer Euclidean distance unit.
//
//   channel   dir  beat contents (low bit up)
//   s_axis    in   first_x, first_y, second_x, second_y (32 bits each)
//   m_axis    out  distance (17 bits), zero padded to 24
//
// One beat per cycle in, one per cycle out while m_axis is ready. There are four
// front stages (difference, magnitude, square, sum) and one stage per root bit (18).
// Every stage holds its own valid bit and moves when empty or when the stage
// after it moves, so a stall at m_axis fills bubbles before s_axis stops.
// Reset clears all valid bits; the data registers are not reset.
module euclidean_distance_integer_unit
  import edi_pkg::*;
#(
  parameter int unsigned COORD_BITS = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [IN_W-1:0] s_axis_tdata,   // first_x, first_y, second_x, second_y
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata   // distance, zero pad
);

  logic  vld  [ROOT_W+1];
  logic  rdy  [ROOT_W+1];
  root_t pipe [ROOT_W+1];

  // Differences through sum of squares
  edi_front #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s_axis_tvalid),
    .ready_o(s_axis_tready),
    .data_i (s_axis_tdata),
    .valid_o(vld[0]),
    .ready_i(rdy[0]),
    .data_o (pipe[0])
  );

  // Square root, most significant bit first
  for (genvar i = 0; i < ROOT_W; i++) begin : g_root
    edi_root_stage #(
      .BIT(ROOT_W - 1 - i)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(vld[i]),
      .ready_o(rdy[i]),
      .data_i (pipe[i]),
      .valid_o(vld[i+1]),
      .ready_i(rdy[i+1]),
      .data_o (pipe[i+1])
    );
  end

  assign rdy[ROOT_W] = m_axis_tready;

  // Clamp oversize results to the field maximum
  logic [DIST_W-1:0] distance;
  always_comb begin
    if (pipe[ROOT_W].sat || (|pipe[ROOT_W].root[ROOT_W-1:DIST_W])) begin
      distance = DIST_MAX;
    end else begin
      distance = pipe[ROOT_W].root[DIST_W-1:0];
    end
  end

  assign m_axis_tvalid = vld[ROOT_W];
  assign m_axis_tdata  = {{(OUT_W - DIST_W){1'b0}}, distance};

endmodule

/* src/edi_checker.sv */
// Port-level checker for the integer distance unit, bound to the top level.
`include "euclidean_distance_integer_unit_macros.svh"

module edi_checker
  import edi_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [IN_W-1:0]  s_axis_tdata,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  // A stalled input beat holds until taken
  `EDI_ASSERT(a_in_hold, s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata), "input beat changed while stalled")

  // A stalled output beat holds
  `EDI_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output beat changed while stalled")

  // A free output side always lets input in
  `EDI_ASSERT(a_in_free, (m_axis_tready || !m_axis_tvalid) |-> s_axis_tready, "input blocked with output free")

  // Pad bits above the distance stay zero
  `EDI_ASSERT_ALWAYS(a_pad_zero, m_axis_tdata[OUT_W-1:DIST_W] == '0, "nonzero pad bits in output beat")

endmodule

bind euclidean_distance_integer_unit edi_checker u_edi_checker (.*);

/* bench/tb_euclidean_distance_integer_unit.sv */
// Self-checking testbench for the integer Euclidean distance unit.
module tb_euclidean_distance_integer_unit;
  import edi_pkg::*;

  localparam int unsigned COORD_BITS = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned SPAN_LIMIT = 1 << DIST_W;
  localparam int unsigned PIPE_DEPTH = 22;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RAND_PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 125;
  localparam int unsigned ROW_COUNT = 21;

  // Row check source: typed-in distance or the predictor
  localparam logic TYPED   = 1'b1;
  localparam logic MODELED = 1'b0;

  typedef logic [FIELD_W-1:0] coord_t;

  typedef struct packed {
    coord_t            ax;
    coord_t            ay;
    coord_t            bx;
    coord_t            by;
    logic              typed;
    logic [DIST_W-1:0] exp_dist;
  } pair_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;   // first_x, first_y, second_x, second_y
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;   // distance, zero pad

  logic [DIST_W-1:0] pending_distances[$];
  int unsigned       mismatch_count;
  int unsigned       idle_cycles;
  bit                src_gaps_on;
  bit                sink_gaps_on;
  bit                hold_out;

  // Directed pairs: extremes, truncation toward zero on both signs, exact roots
  pair_row_t directed_rows[ROW_COUNT] = '{
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, TYPED, 17'd0},
    '{32'h0003_0000, 32'h0004_0000, 32'h0000_0000, 32'h0000_0000, TYPED, 17'd5},
    '{32'h0000_0000, 32'h0000_0000, 32'h0005_0000, 32'h000C_0000, TYPED, 17'd13},
    '{32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000, TYPED, 17'd65535},
    '{32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000, TYPED, 17'd65535},
    '{32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, TYPED, 17'd65535},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, MODELED, 17'd0},
    '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, MODELED, 17'd0},
    '{32'h0000_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, TYPED, 17'd0},
    '{32'hFFFF_0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, TYPED, 17'd0},
    '{32'hFFFE_8000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, TYPED, 17'd1},
    '{32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, TYPED, 17'd1},
    '{32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5678, 32'h9ABC_DEF0, TYPED, 17'd0},
    '{32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, TYPED, 17'd1},
    '{32'h0002_0000, 32'h0002_0000, 32'h0000_0000, 32'h0000_0000, TYPED, 17'd2},
    '{32'h0003_0000, 32'h0003_0000, 32'h0000_0000, 32'h0000_0000, TYPED, 17'd4},
    '{32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, TYPED, 17'd32768},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, TYPED, 17'd0},
    '{32'h0001_8000, 32'h0000_0000, 32'hFFFF_8000, 32'h0000_0000, TYPED, 17'd2},
    '{32'h4000_0000, 32'hC000_0000, 32'hC000_0000, 32'h4000_0000, MODELED, 17'd0},
    '{32'h00FF_0000, 32'hFF01_0000, 32'h0000_0000, 32'h0000_0000, MODELED, 17'd0}
  };

  euclidean_distance_integer_unit #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Integer part of |a - b|, formed wide enough that it never wraps
  function automatic logic [63:0] axis_span(input coord_t a, input coord_t b);
    logic signed [FIELD_W+1:0] delta;
    logic [FIELD_W+1:0]        mag;
    delta = $signed({{2{a[FIELD_W-1]}}, a}) - $signed({{2{b[FIELD_W-1]}}, b});
    mag = delta[FIELD_W+1] ? -delta : delta;
    return 64'(mag >> FRAC_BITS);
  endfunction

  // Floor of the square root, one result bit per step
  function automatic logic [63:0] floor_root(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] probe;
    logic [63:0] rem;
    root  = '0;
    rem   = n;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic logic [DIST_W-1:0] predict_distance(input coord_t ax, input coord_t ay,
                                                         input coord_t bx, input coord_t by);
    logic [63:0] ix;
    logic [63:0] iy;
    logic [63:0] root;
    ix = axis_span(ax, bx);
    iy = axis_span(ay, by);
    if (ix >= SPAN_LIMIT || iy >= SPAN_LIMIT) return DIST_MAX;
    root = floor_root(ix * ix + iy * iy);
    if (root > 64'(DIST_MAX)) return DIST_MAX;
    return root[DIST_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Offer one beat, after a random gap when source gaps are on; record its distance once accepted
  task automatic send_point_pair(input coord_t ax, input coord_t ay, input coord_t bx,
                                 input coord_t by, input logic [DIST_W-1:0] exp_dist);
    int unsigned gap;
    gap = src_gaps_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {by, bx, ay, ax};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_distances.push_back(exp_dist);
    @(negedge clk_i);
  endtask

  // Stop offering and wait for the pipeline to empty
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending_distances.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: random stall before each beat when sink gaps are on, one long hold-off on request
  initial begin
    int unsigned gap;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      gap = 0;
      if (hold_out) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_out = 1'b0;
      end else if (sink_gaps_on) begin
        gap = $urandom_range(0, 4);
      end
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // Compare every output beat with the oldest pending distance
  always @(posedge clk_i) begin
    logic [DIST_W-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_distances.size() == 0) begin
        report_mismatch($sformatf("unexpected beat, tdata=%h", m_axis_tdata));
      end else begin
        want = pending_distances.pop_front();
        if (m_axis_tdata[DIST_W-1:0] !== want)
          report_mismatch($sformatf("distance %0d, want %0d",
                                    m_axis_tdata[DIST_W-1:0], want));
        if (m_axis_tdata[OUT_W-1:DIST_W] !== '0)
          report_mismatch($sformatf("pad bits %h not zero", m_axis_tdata[OUT_W-1:DIST_W]));
      end
    end
  end

  // Watchdog: end the run when neither side moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t corner_vals[6];
    int     offset;
    int     kind;
    corner_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                    32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_0000};
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    src_gaps_on    = 1'b1;
    sink_gaps_on   = 1'b1;
    hold_out       = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Walk the directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed == TYPED)
        send_point_pair(directed_rows[i].ax, directed_rows[i].ay, directed_rows[i].bx,
                        directed_rows[i].by, directed_rows[i].exp_dist);
      else
        send_point_pair(directed_rows[i].ax, directed_rows[i].ay, directed_rows[i].bx,
                        directed_rows[i].by,
                        predict_distance(directed_rows[i].ax, directed_rows[i].ay,
                                         directed_rows[i].bx, directed_rows[i].by));
    end

    // Random phases with varying idle patterns on both sides
    for (int p = 0; p < RAND_PHASES; p++) begin
      src_gaps_on  = (p % 3) != 0;
      sink_gaps_on = (p % 4) != 1;
      if (p == 2) begin
        src_gaps_on = 1'b0;
        hold_out    = 1'b1;
      end
      if (p == 6) drain_results();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
          // Fully random coordinates
          ax = $urandom;
          ay = $urandom;
          bx = $urandom;
          by = $urandom;
        end else if (kind < 70) begin
          // Nearby points: short distances with fractional parts
          ax = $urandom;
          ay = $urandom;
          offset = int'($urandom_range(0, 2097152)) - 1048576;
          bx = ax + coord_t'(offset);
          offset = int'($urandom_range(0, 2097152)) - 1048576;
          by = ay + coord_t'(offset);
        end else if (kind < 85) begin
          // Whole-number coordinates near the origin
          ax = coord_t'((int'($urandom_range(0, 400)) - 200) <<< FRAC_BITS);
          ay = coord_t'((int'($urandom_range(0, 400)) - 200) <<< FRAC_BITS);
          bx = coord_t'((int'($urandom_range(0, 400)) - 200) <<< FRAC_BITS);
          by = coord_t'((int'($urandom_range(0, 400)) - 200) <<< FRAC_BITS);
        end else begin
          // Corner values of the coordinate range
          ax = corner_vals[$urandom_range(0, 5)];
          ay = corner_vals[$urandom_range(0, 5)];
          bx = corner_vals[$urandom_range(0, 5)];
          by = corner_vals[$urandom_range(0, 5)];
        end
        send_point_pair(ax, ay, bx, by, predict_distance(ax, ay, bx, by));
      end
    end

    // Drain, then watch a little longer for stray beats
    s_axis_tvalid <= 1'b0;
    while (pending_distances.size() != 0) @(negedge clk_i);
    repeat (PIPE_DEPTH + 8) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
